[rtl/lfps_pkg.sv]
// Shared widths, constants and helpers of the five-point second-derivative stencil.
package lfps_pkg;

    localparam int SAMPLE_WIDTH = 24;
    // Stencil coefficient magnitudes sum to 64, so a sum needs seven bits above a sample.
    localparam int SUM_W   = SAMPLE_WIDTH + 7;
    localparam int SCALE_W = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = SUM_W + SCALE_W + 1;
    localparam int SH_W    = PROD_W - FRAC_W;
    localparam int OUT_W   = 48;
    localparam int EXT_W   = SH_W + OUT_W;
    localparam int SEEN_W  = 3;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

    localparam logic signed [SUM_W-1:0] K16 = SUM_W'(16);
    localparam logic signed [SUM_W-1:0] K17 = SUM_W'(17);
    localparam logic signed [SUM_W-1:0] K30 = SUM_W'(30);
    localparam logic signed [SUM_W-1:0] K46 = SUM_W'(46);

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic signed [EXT_W-1:0] EXT_MAX = EXT_W'(OUT_MAX);
    localparam logic signed [EXT_W-1:0] EXT_MIN = EXT_W'(OUT_MIN);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]        t_sum;

    // Flags that travel with each result through the scaling pipeline.
    typedef struct packed {
        logic fin;
        logic err;
    } t_tag;

    // Clamps a shifted product to the signed output range.
    function automatic logic signed [OUT_W-1:0] f_sat(input logic signed [SH_W-1:0] v);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(v);
        if (e > EXT_MAX) begin
            return OUT_MAX;
        end else if (e < EXT_MIN) begin
            return OUT_MIN;
        end else begin
            return e[OUT_W-1:0];
        end
    endfunction

endpackage

[rtl/lfps_tap_cell.sv]
// One window cell: holds a sample and passes it to the next cell on each shift.
module lfps_tap_cell
    import lfps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_shift,
    input  logic    i_clear,
    input  t_sample i_d,
    output t_sample o_q
);

    t_sample r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

[rtl/lfps_scaler.sv]
// Two-stage scaling pipeline: signed multiply by the scale, then shift and saturate.
module lfps_scaler
    import lfps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [SCALE_W-1:0]       i_scale,
    input  logic                     i_valid,
    input  t_sum                     i_sum,
    input  t_tag                     i_tag,
    output logic                     o_ready,
    output logic                     o_valid,
    output logic signed [OUT_W-1:0]  o_derivative,
    output t_tag                     o_tag,
    input  logic                     i_ready
);

    logic                      r_b_valid;
    logic signed [PROD_W-1:0]  r_b_prod;
    t_tag                      r_b_tag;
    logic                      r_c_valid;
    logic signed [OUT_W-1:0]   r_c_data;
    t_tag                      r_c_tag;

    logic                      c_free;
    logic                      b_free;
    logic signed [PROD_W-1:0]  n_b_prod;

    assign c_free = !r_c_valid || i_ready;
    assign b_free = !r_b_valid || c_free;

    // A floor shift of the signed product matches rounding toward minus infinity.
    assign n_b_prod = PROD_W'(i_sum) * PROD_W'($signed({1'b0, i_scale}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (b_free) begin
                r_b_valid <= i_valid;
            end
            if (c_free) begin
                r_c_valid <= r_b_valid;
            end
        end
        if (b_free && i_valid) begin
            r_b_prod <= n_b_prod;
            r_b_tag  <= i_tag;
        end
        if (c_free && r_b_valid) begin
            r_c_data <= f_sat($signed(r_b_prod[PROD_W-1:FRAC_W]));
            r_c_tag  <= r_b_tag;
        end
    end

    assign o_ready      = b_free;
    assign o_valid      = r_c_valid;
    assign o_derivative = r_c_data;
    assign o_tag        = r_c_tag;

endmodule

[rtl/laplacian_five_point_stencil.sv]
// Top level of the streamed fourth-order second-derivative stencil.
//
//  Channel   Direction  Signals                                     Transfer when
//  -------   ---------  ------------------------------------------  -------------------------
//  input     in         i_sample, i_last                            i_in_valid & o_in_ready
//  output    out        o_derivative, o_final_res, o_error          o_out_valid & i_out_ready
//  config    APB        psel, penable, pwrite, paddr, pwdata, ...   psel & penable & pwrite
//
// One sample is taken per cycle while o_in_ready is high. The last sample of a
// run of four or more samples produces three results, which share the single
// multiplier one per cycle unless stalled, so that sample holds the front stage
// until all three have left. Each result then passes the product register and
// the output register. Reset is synchronous and active low; it empties every
// stage, clears the window and restores the scale. A stall on the output fills
// the two pipeline registers and the front stage, and then holds o_in_ready low.
module laplacian_five_point_stencil
    import lfps_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Sample stream.
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_last,
    // Result stream.
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_derivative,
    output logic                    o_final_res,
    output logic                    o_error,
    // Register port.
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    // Register index of the scale, taken from the word address bit.
    localparam logic REG_SCALE = 1'b0;

    logic [SCALE_W-1:0] r_scale;
    logic [SEEN_W-1:0]  r_seen;

    // Front stage: up to three stencil sums waiting for the multiplier.
    logic               r_a_valid;
    logic [1:0]         r_a_cnt;
    t_sum               r_a_sum [0:2];
    logic               r_a_fin;
    logic               r_a_err;

    logic               accept;
    logic               issue;
    logic               sc_ready;
    logic               has_out;
    logic [1:0]         n_a_cnt;
    t_sum               n_a_sum [0:2];
    logic               n_a_err;
    t_tag               issue_tag;
    t_tag               out_tag;

    t_sample            win [0:3];
    t_sum               e0, e1, e2, e3, ec;
    t_sum               s_int, s_p0, s_p1, s_n2, s_n1;

    // ---------------------------------------------------------------------------
    // Register port. Every access completes in its access cycle.
    // ---------------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SCALE) ? r_scale : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SCALE)) begin
            r_scale <= pwdata;
        end
    end

    // ---------------------------------------------------------------------------
    // Window: a chain of four cells. Cell 3 holds the newest sample; each shift
    // moves every sample one cell toward cell 0. The last sample clears the chain.
    // ---------------------------------------------------------------------------
    assign accept = i_in_valid && o_in_ready;

    for (genvar g = 0; g < 4; g++) begin : g_tap
        lfps_tap_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (accept && !i_last),
            .i_clear (accept && i_last),
            .i_d     ((g == 3) ? i_sample : win[(g + 1) % 4]),
            .o_q     (win[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_seen <= '0;
            end else if (r_seen < SEEN_W'(4)) begin
                r_seen <= r_seen + SEEN_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------------------
    // Stencil sums. The constant products reduce to shifts and adds.
    // ---------------------------------------------------------------------------
    assign e0 = SUM_W'(win[0]);
    assign e1 = SUM_W'(win[1]);
    assign e2 = SUM_W'(win[2]);
    assign e3 = SUM_W'(win[3]);
    assign ec = SUM_W'(i_sample);

    assign s_int = K16 * e1 - e0 - K30 * e2 + K16 * e3 - ec;
    assign s_p1  = K17 * e1 - K30 * e2 + K16 * e3 - ec;
    assign s_p0  = K17 * e3 - K46 * e2 - ec;
    assign s_n2  = K16 * e2 - e1 - K30 * e3 + K17 * ec;
    assign s_n1  = K17 * e3 - e2 - K46 * ec;

    // A run of fewer than four samples ends with a single error result of zero.
    always_comb begin
        has_out    = 1'b0;
        n_a_cnt    = 2'd1;
        n_a_err    = 1'b0;
        n_a_sum[0] = s_int;
        n_a_sum[1] = s_n2;
        n_a_sum[2] = s_n1;
        if (i_last) begin
            has_out = 1'b1;
            if (r_seen < SEEN_W'(3)) begin
                n_a_err    = 1'b1;
                n_a_sum[0] = '0;
            end else begin
                n_a_cnt = 2'd3;
                if (r_seen == SEEN_W'(3)) begin
                    n_a_sum[0] = s_p1;
                end
            end
        end else begin
            case (r_seen)
                SEEN_W'(2): begin
                    has_out    = 1'b1;
                    n_a_sum[0] = s_p0;
                end
                SEEN_W'(3): begin
                    has_out    = 1'b1;
                    n_a_sum[0] = s_p1;
                end
                SEEN_W'(4): begin
                    has_out = 1'b1;
                end
                default: begin
                    has_out = 1'b0;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------------
    // Front stage. It hands one sum per cycle to the scaler while sc_ready is high
    // and takes a new sample in the same cycle as its final sum leaves.
    // ---------------------------------------------------------------------------
    assign issue      = r_a_valid && sc_ready;
    assign o_in_ready = !r_a_valid || (sc_ready && (r_a_cnt == 2'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_cnt   <= 2'd1;
        end else if (accept) begin
            r_a_valid <= has_out;
            r_a_cnt   <= n_a_cnt;
        end else if (issue) begin
            if (r_a_cnt == 2'd1) begin
                r_a_valid <= 1'b0;
            end else begin
                r_a_cnt <= r_a_cnt - 2'd1;
            end
        end
        if (accept) begin
            r_a_sum[0] <= n_a_sum[0];
            r_a_sum[1] <= n_a_sum[1];
            r_a_sum[2] <= n_a_sum[2];
            r_a_fin    <= i_last;
            r_a_err    <= n_a_err;
        end else if (issue) begin
            r_a_sum[0] <= r_a_sum[1];
            r_a_sum[1] <= r_a_sum[2];
        end
    end

    // Only the final sum of a run's closing group carries the end-of-run flag.
    assign issue_tag.fin = r_a_fin && (r_a_cnt == 2'd1);
    assign issue_tag.err = r_a_err;

    lfps_scaler u_scaler (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scale      (r_scale),
        .i_valid      (r_a_valid),
        .i_sum        (r_a_sum[0]),
        .i_tag        (issue_tag),
        .o_ready      (sc_ready),
        .o_valid      (o_out_valid),
        .o_derivative (o_derivative),
        .o_tag        (out_tag),
        .i_ready      (i_out_ready)
    );

    assign o_final_res = out_tag.fin;
    assign o_error     = out_tag.err;

endmodule
